// ===== rtl/lsb_pkg.sv =====
// ----------------------------------------------------------------------------
// lsb_pkg: shared definitions for the lsb stego extractor
// widths, register indexes and result kind codes
// ----------------------------------------------------------------------------
package lsb_pkg;

    // bits in each length field of the hidden frame
    localparam int LENGTH_BITS      = 32;
    // most magic characters the magic word register can hold
    localparam int MAX_MAGIC_CHARS  = 8;
    // bits per hidden character
    localparam int CHAR_BITS        = 8;

    // derived widths
    localparam int BIT_IDX_W        = $clog2(LENGTH_BITS);
    localparam int MAGIC_LEN_W      = 4;
    localparam int MAGIC_WORD_W     = 64;
    localparam int HEADER_W         = 8;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 64;
    localparam int MAGIC_SEL_W      = 3;

    // reset value of the header skip register
    localparam logic [HEADER_W-1:0] HEADER_SKIP_RST = HEADER_W'(54);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_SKIP  = 2'd0,
        CFG_MAGIC_LENGTH = 2'd1,
        CFG_MAGIC_WORD   = 2'd2
    } t_cfg_idx;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_EXT  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

endpackage

// ===== rtl/lsb_stego_extractor.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_extractor: least significant bit steganography extractor
// skips an image header, then rebuilds magic, extension and data sections
// from the lowest bit of each image byte
// ----------------------------------------------------------------------------
// Image bytes enter one item per clock on the slave stream, with tuser set on
// the first header byte of a new frame. Every byte is handled at once: the
// bit counter, gather register and section state update at the moment the
// item is accepted, and any result lands in one output register. The block
// takes a byte every cycle while that output register is empty or being
// drained, so throughput is one byte per clock; a result appears on the
// master stream in the cycle after the byte that completes its character. A
// magic mismatch gives a single error item (kind 2) and the block then drops
// bytes until the next frame start; after the data section it does the same.
// Configuration writes are always accepted and should be made between frames.
// ----------------------------------------------------------------------------
module lsb_stego_extractor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // image byte stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] pixel_byte
    input  logic                             s_axis_tuser,  // [0] frame_start
    // decoded character stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]                       m_axis_tuser,  // [1:0] out_kind
    output logic                             m_axis_tlast,  // section_last
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lsb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lsb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lsb_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_MAGIC_LEN = 3'd1,
        PH_MAGIC     = 3'd2,
        PH_EXT_LEN   = 3'd3,
        PH_EXT       = 3'd4,
        PH_DATA_LEN  = 3'd5,
        PH_DATA      = 3'd6,
        PH_IDLE      = 3'd7
    } t_phase;

    // configuration registers
    logic [HEADER_W-1:0]     r_header_skip;
    logic [MAGIC_LEN_W-1:0]  r_magic_length;
    logic [MAGIC_WORD_W-1:0] r_magic_word;

    // decode state
    t_phase                  r_phase,  n_phase;
    logic [HEADER_W-1:0]     r_hdr_cnt, n_hdr_cnt;
    logic [BIT_IDX_W-1:0]    r_bit_idx, n_bit_idx;
    logic [LENGTH_BITS-1:0]  r_gather, n_gather;
    logic [LENGTH_BITS-1:0]  r_remain, n_remain;
    logic [MAGIC_LEN_W-1:0]  r_magic_pos, n_magic_pos;

    // output register
    logic                    r_out_valid;
    logic [CHAR_BITS-1:0]    r_out_byte, n_out_byte;
    t_kind                   r_out_kind, n_out_kind;
    logic                    r_out_last, n_out_last;
    logic                    n_emit;

    // state as seen by this item, after a possible frame restart
    t_phase                  e_phase;
    logic [HEADER_W-1:0]     e_hdr_cnt;
    logic [BIT_IDX_W-1:0]    e_bit_idx;
    logic [LENGTH_BITS-1:0]  e_gather;
    logic [LENGTH_BITS-1:0]  e_remain;
    logic [MAGIC_LEN_W-1:0]  e_magic_pos;

    logic                    s_accept;
    logic                    is_len;
    logic                    field_done;
    logic [LENGTH_BITS-1:0]  value;
    logic [CHAR_BITS-1:0]    expected;
    logic [MAGIC_LEN_W-1:0]  pos_inc;
    logic [LENGTH_BITS-1:0]  remain_dec;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // frame restart clears state before the byte is used
    always_comb begin
        if (s_axis_tuser) begin
            e_phase     = PH_HEADER;
            e_hdr_cnt   = '0;
            e_bit_idx   = '0;
            e_gather    = '0;
            e_remain    = '0;
            e_magic_pos = '0;
        end else begin
            e_phase     = r_phase;
            e_hdr_cnt   = r_hdr_cnt;
            e_bit_idx   = r_bit_idx;
            e_gather    = r_gather;
            e_remain    = r_remain;
            e_magic_pos = r_magic_pos;
        end
    end

    // per-byte decode step
    always_comb begin
        n_phase     = e_phase;
        n_hdr_cnt   = e_hdr_cnt;
        n_bit_idx   = e_bit_idx;
        n_gather    = e_gather;
        n_remain    = e_remain;
        n_magic_pos = e_magic_pos;
        n_emit      = 1'b0;
        n_out_byte  = '0;
        n_out_kind  = KIND_ERR;
        n_out_last  = 1'b0;

        is_len      = 1'b0;
        field_done  = 1'b0;
        value       = '0;
        expected    = r_magic_word[e_magic_pos[MAGIC_SEL_W-1:0]*CHAR_BITS +: CHAR_BITS];
        pos_inc     = e_magic_pos + MAGIC_LEN_W'(1);
        remain_dec  = (e_remain == '0) ? '0 : e_remain - LENGTH_BITS'(1);

        if (e_phase == PH_HEADER && e_hdr_cnt < r_header_skip) begin
            n_hdr_cnt = e_hdr_cnt + HEADER_W'(1);
        end else if (e_phase != PH_IDLE) begin
            if (e_phase == PH_HEADER) begin
                n_phase = PH_MAGIC_LEN;
            end
            is_len = (e_phase == PH_HEADER) || (e_phase == PH_MAGIC_LEN) ||
                     (e_phase == PH_EXT_LEN) || (e_phase == PH_DATA_LEN);
            value  = e_gather | (LENGTH_BITS'(s_axis_tdata[0]) << e_bit_idx);
            field_done = is_len ? (e_bit_idx == BIT_IDX_W'(LENGTH_BITS - 1))
                                : (e_bit_idx == BIT_IDX_W'(CHAR_BITS - 1));
            if (!field_done) begin
                n_gather  = value;
                n_bit_idx = e_bit_idx + BIT_IDX_W'(1);
            end else begin
                n_gather  = '0;
                n_bit_idx = '0;
                unique case (e_phase)
                    PH_HEADER, PH_MAGIC_LEN: begin
                        if (r_magic_length > MAGIC_LEN_W'(MAX_MAGIC_CHARS) ||
                            value != LENGTH_BITS'(r_magic_length)) begin
                            n_phase = PH_IDLE;
                            n_emit  = 1'b1;
                        end else begin
                            n_magic_pos = '0;
                            n_phase     = (value == '0) ? PH_EXT_LEN : PH_MAGIC;
                        end
                    end
                    PH_MAGIC: begin
                        if (value[CHAR_BITS-1:0] != expected) begin
                            n_phase = PH_IDLE;
                            n_emit  = 1'b1;
                        end else begin
                            n_magic_pos = pos_inc;
                            n_phase     = (pos_inc >= r_magic_length) ? PH_EXT_LEN
                                                                      : PH_MAGIC;
                        end
                    end
                    PH_EXT_LEN: begin
                        n_remain = value;
                        n_phase  = (value != '0) ? PH_EXT : PH_DATA_LEN;
                    end
                    PH_DATA_LEN: begin
                        n_remain = value;
                        n_phase  = (value != '0) ? PH_DATA : PH_IDLE;
                    end
                    PH_EXT, PH_DATA: begin
                        n_emit     = 1'b1;
                        n_out_byte = value[CHAR_BITS-1:0];
                        n_out_kind = (e_phase == PH_EXT) ? KIND_EXT : KIND_DATA;
                        n_out_last = (e_remain <= LENGTH_BITS'(1));
                        n_remain   = remain_dec;
                        if (remain_dec == '0) begin
                            n_phase = (e_phase == PH_EXT) ? PH_DATA_LEN : PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // decode state and output register, refilled as it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_bit_idx   <= '0;
            r_gather    <= '0;
            r_remain    <= '0;
            r_magic_pos <= '0;
            r_out_valid <= 1'b0;
            r_out_byte  <= '0;
            r_out_kind  <= KIND_EXT;
            r_out_last  <= 1'b0;
        end else if (s_accept) begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_bit_idx   <= n_bit_idx;
            r_gather    <= n_gather;
            r_remain    <= n_remain;
            r_magic_pos <= n_magic_pos;
            r_out_valid <= n_emit;
            if (n_emit) begin
                r_out_byte <= n_out_byte;
                r_out_kind <= n_out_kind;
                r_out_last <= n_out_last;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_skip  <= HEADER_SKIP_RST;
            r_magic_length <= '0;
            r_magic_word   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEADER_SKIP:  r_header_skip  <= i_cfg_data[HEADER_W-1:0];
                CFG_MAGIC_LENGTH: r_magic_length <= i_cfg_data[MAGIC_LEN_W-1:0];
                CFG_MAGIC_WORD:   r_magic_word   <= i_cfg_data[MAGIC_WORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
